>>> rtl/core/aiq_pkg.sv
// Shared types and constants for the box intersection query block.
package aiq_pkg;

  typedef enum logic [1:0] {
    OP_BOX     = 2'd0,
    OP_POINT   = 2'd1,
    OP_SEGMENT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_HALF_X   = 3'd3;
  localparam logic [2:0] REG_HALF_Y   = 3'd4;
  localparam logic [2:0] REG_HALF_Z   = 3'd5;

  localparam int NAXIS = 3;
  localparam int NDIV  = 6;

  typedef struct packed {
    op_t              op;
    logic             ok_box;
    logic             ok_pt;
    logic [NAXIS-1:0] dz;
    logic [NAXIS-1:0] zin;
    logic [NDIV-1:0]  neg;
    logic [NDIV-1:0]  sat;
  } tag_t;

endpackage

>>> rtl/core/aiq_if.sv
// Channel interfaces for query, result and configuration transactions.
interface aiq_query_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic signed [COORD_BITS-1:0] point_a_x;
  logic signed [COORD_BITS-1:0] point_a_y;
  logic signed [COORD_BITS-1:0] point_a_z;
  logic signed [COORD_BITS-1:0] point_b_x;
  logic signed [COORD_BITS-1:0] point_b_y;
  logic signed [COORD_BITS-1:0] point_b_z;
  logic [COORD_BITS-2:0]        other_half_x;
  logic [COORD_BITS-2:0]        other_half_y;
  logic [COORD_BITS-2:0]        other_half_z;

  modport source (output valid, opcode, point_a_x, point_a_y, point_a_z,
                  point_b_x, point_b_y, point_b_z,
                  other_half_x, other_half_y, other_half_z,
                  input ready);
  modport sink (input valid, opcode, point_a_x, point_a_y, point_a_z,
                point_b_x, point_b_y, point_b_z,
                other_half_x, other_half_y, other_half_z,
                output ready);
endinterface

interface aiq_result_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

interface aiq_cfg_if #(parameter int COORD_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [2:0]            idx;
  logic [COORD_BITS-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

>>> rtl/core/aiq_div_cell.sv
// One restoring-division cell: resolves one quotient bit for all six slab dividers.
module aiq_div_cell #(
  parameter int XW  = 63,
  parameter int QW  = 31,
  parameter int BIT = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                v_i,
  input  aiq_pkg::tag_t                       tag_i,
  input  logic [aiq_pkg::NDIV-1:0][XW-1:0]    rem_i,
  input  logic [aiq_pkg::NDIV-1:0][XW-1:0]    den_i,
  input  logic [aiq_pkg::NDIV-1:0][QW-1:0]    q_i,
  output logic                                v_o,
  output aiq_pkg::tag_t                       tag_o,
  output logic [aiq_pkg::NDIV-1:0][XW-1:0]    rem_o,
  output logic [aiq_pkg::NDIV-1:0][XW-1:0]    den_o,
  output logic [aiq_pkg::NDIV-1:0][QW-1:0]    q_o
);
  import aiq_pkg::*;

  logic                     v_r;
  tag_t                     tag_r;
  logic [NDIV-1:0][XW-1:0]  rem_r, rem_nxt, den_r, dsh;
  logic [NDIV-1:0][QW-1:0]  q_r, q_nxt;

  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      dsh[k]     = den_i[k] << BIT;
      rem_nxt[k] = rem_i[k];
      q_nxt[k]   = q_i[k];
      if (rem_i[k] >= dsh[k]) begin
        rem_nxt[k]    = rem_i[k] - dsh[k];
        q_nxt[k][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r <= tag_i;
      rem_r <= rem_nxt;
      den_r <= den_i;
      q_r   <= q_nxt;
    end
  end

  assign v_o   = v_r;
  assign tag_o = tag_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
  assign q_o   = q_r;

endmodule

>>> rtl/core/aiq_slab_cell.sv
// One slab cell: clips the segment parameter interval against one axis.
module aiq_slab_cell #(
  parameter int CW   = 32,
  parameter int AXIS = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              v_i,
  input  aiq_pkg::tag_t                     tag_i,
  input  logic [aiq_pkg::NDIV-1:0][CW-1:0]  t_i,
  input  logic signed [CW-1:0]              te_i,
  input  logic signed [CW-1:0]              tx_i,
  input  logic                              alive_i,
  output logic                              v_o,
  output aiq_pkg::tag_t                     tag_o,
  output logic [aiq_pkg::NDIV-1:0][CW-1:0]  t_o,
  output logic signed [CW-1:0]              te_o,
  output logic signed [CW-1:0]              tx_o,
  output logic                              alive_o
);
  import aiq_pkg::*;

  logic                     v_r, alive_r, alive_nxt;
  tag_t                     tag_r;
  logic [NDIV-1:0][CW-1:0]  t_r;
  logic signed [CW-1:0]     te_r, tx_r, te_nxt, tx_nxt;
  logic signed [CW-1:0]     t1, t2, tlo, thi;

  always_comb begin
    t1        = t_i[2*AXIS];
    t2        = t_i[2*AXIS+1];
    tlo       = (t1 > t2) ? t2 : t1;
    thi       = (t1 > t2) ? t1 : t2;
    te_nxt    = te_i;
    tx_nxt    = tx_i;
    alive_nxt = alive_i;
    if (tag_i.dz[AXIS]) begin
      alive_nxt = alive_i && tag_i.zin[AXIS];
    end else if ((te_i > thi) || (tlo > tx_i)) begin
      alive_nxt = 1'b0;
    end else begin
      if (tlo > te_i) te_nxt = tlo;
      if (thi < tx_i) tx_nxt = thi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r   <= tag_i;
      t_r     <= t_i;
      te_r    <= te_nxt;
      tx_r    <= tx_nxt;
      alive_r <= alive_nxt;
    end
  end

  assign v_o     = v_r;
  assign tag_o   = tag_r;
  assign t_o     = t_r;
  assign te_o    = te_r;
  assign tx_o    = tx_r;
  assign alive_o = alive_r;

endmodule

>>> rtl/core/aabb_intersection_query.sv
// Top level of the box intersection query block.
// Throughput: one query per cycle while the output stage is not full; the divider cell row
// resolves one quotient bit per stage. A two-entry output stage keeps taking queries while
// one result waits to be taken; once both entries are full the pipeline stalls.
// Reset (synchronous, active low) clears the box registers to zero and empties the pipeline.
module aabb_intersection_query #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  aiq_query_if.sink     in_ch,
  aiq_result_if.source  out_ch,
  aiq_cfg_if.sink       cfg_ch
);
  import aiq_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int HW = C - 1;
  localparam int EW = C + 1;
  localparam int NW = C + 2;
  localparam int MW = C + 1;
  localparam int QW = C - 1;
  localparam int XW = (C + 1 + FRAC_BITS > 2 * C - 1) ? C + 1 + FRAC_BITS : 2 * C - 1;
  localparam logic signed [C-1:0] T_ONE = {{(C-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic en;

  // box registers
  logic signed [C-1:0]  ctr_r [NAXIS];
  logic [HW-1:0]        half_r [NAXIS];
  logic signed [EW-1:0] lo_r [NAXIS];
  logic signed [EW-1:0] hi_r [NAXIS];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NAXIS; k++) begin
        ctr_r[k]  <= '0;
        half_r[k] <= '0;
        lo_r[k]   <= '0;
        hi_r[k]   <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.idx)
          REG_CENTER_X: ctr_r[0]  <= cfg_ch.data;
          REG_CENTER_Y: ctr_r[1]  <= cfg_ch.data;
          REG_CENTER_Z: ctr_r[2]  <= cfg_ch.data;
          REG_HALF_X:   half_r[0] <= cfg_ch.data[HW-1:0];
          REG_HALF_Y:   half_r[1] <= cfg_ch.data[HW-1:0];
          REG_HALF_Z:   half_r[2] <= cfg_ch.data[HW-1:0];
          default: ;
        endcase
      end
      for (int k = 0; k < NAXIS; k++) begin
        lo_r[k] <= {ctr_r[k][C-1], ctr_r[k]} - {2'b00, half_r[k]};
        hi_r[k] <= {ctr_r[k][C-1], ctr_r[k]} + {2'b00, half_r[k]};
      end
    end
  end

  // stage 1: capture query
  logic signed [C-1:0] in_a [NAXIS];
  logic signed [C-1:0] in_b [NAXIS];
  logic [HW-1:0]       in_oh [NAXIS];

  assign in_a[0]  = in_ch.point_a_x;
  assign in_a[1]  = in_ch.point_a_y;
  assign in_a[2]  = in_ch.point_a_z;
  assign in_b[0]  = in_ch.point_b_x;
  assign in_b[1]  = in_ch.point_b_y;
  assign in_b[2]  = in_ch.point_b_z;
  assign in_oh[0] = in_ch.other_half_x;
  assign in_oh[1] = in_ch.other_half_y;
  assign in_oh[2] = in_ch.other_half_z;
  assign in_ch.ready = en;

  logic                v1_r;
  op_t                 op1_r;
  logic signed [C-1:0] a1_r [NAXIS];
  logic signed [C-1:0] b1_r [NAXIS];
  logic [HW-1:0]       oh1_r [NAXIS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= op_t'(in_ch.opcode);
      for (int k = 0; k < NAXIS; k++) begin
        a1_r[k]  <= in_a[k];
        b1_r[k]  <= in_b[k];
        oh1_r[k] <= in_oh[k];
      end
    end
  end

  // stage 2: differences against the box
  logic signed [EW-1:0] ae2 [NAXIS];
  logic signed [EW-1:0] dc2 [NAXIS];
  logic signed [EW-1:0] d2 [NAXIS];
  logic [C-1:0]         hs2 [NAXIS];
  logic signed [NW-1:0] nlo2 [NAXIS];
  logic signed [NW-1:0] nhi2 [NAXIS];
  logic                 pin2 [NAXIS];
  logic                 zin2 [NAXIS];

  always_comb begin
    for (int k = 0; k < NAXIS; k++) begin
      ae2[k]  = {a1_r[k][C-1], a1_r[k]};
      dc2[k]  = {ctr_r[k][C-1], ctr_r[k]} - ae2[k];
      d2[k]   = {b1_r[k][C-1], b1_r[k]} - ae2[k];
      hs2[k]  = {1'b0, half_r[k]} + {1'b0, oh1_r[k]};
      nlo2[k] = {lo_r[k][EW-1], lo_r[k]} - {ae2[k][EW-1], ae2[k]};
      nhi2[k] = {hi_r[k][EW-1], hi_r[k]} - {ae2[k][EW-1], ae2[k]};
      pin2[k] = (ae2[k] > lo_r[k]) && (ae2[k] < hi_r[k]);
      zin2[k] = (ae2[k] >= lo_r[k]) && (ae2[k] <= hi_r[k]);
    end
  end

  logic                 v2_r;
  op_t                  op2_r;
  logic signed [EW-1:0] dc2_r [NAXIS];
  logic signed [EW-1:0] d2_r [NAXIS];
  logic [C-1:0]         hs2_r [NAXIS];
  logic signed [NW-1:0] nlo2_r [NAXIS];
  logic signed [NW-1:0] nhi2_r [NAXIS];
  logic                 pin2_r [NAXIS];
  logic                 zin2_r [NAXIS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r <= op1_r;
      for (int k = 0; k < NAXIS; k++) begin
        dc2_r[k]  <= dc2[k];
        d2_r[k]   <= d2[k];
        hs2_r[k]  <= hs2[k];
        nlo2_r[k] <= nlo2[k];
        nhi2_r[k] <= nhi2[k];
        pin2_r[k] <= pin2[k];
        zin2_r[k] <= zin2[k];
      end
    end
  end

  // stage 3: magnitudes, signs and dividend alignment
  logic [EW-1:0]           adc3 [NAXIS];
  logic [EW-1:0]           dabs3 [NAXIS];
  logic signed [NW-1:0]    num3 [NDIV];
  logic [NW-1:0]           nabs3 [NDIV];
  logic [NDIV-1:0][XW-1:0] rem3, den3;
  tag_t                    tag3;

  always_comb begin
    tag3        = '0;
    tag3.op     = op2_r;
    tag3.ok_box = 1'b1;
    tag3.ok_pt  = 1'b1;
    for (int k = 0; k < NAXIS; k++) begin
      adc3[k]  = dc2_r[k][EW-1] ? EW'(0) - dc2_r[k] : dc2_r[k];
      dabs3[k] = d2_r[k][EW-1] ? EW'(0) - d2_r[k] : d2_r[k];
      if (adc3[k] > {1'b0, hs2_r[k]}) tag3.ok_box = 1'b0;
      if (!pin2_r[k]) tag3.ok_pt = 1'b0;
      tag3.dz[k]    = (d2_r[k] == '0);
      tag3.zin[k]   = zin2_r[k];
      num3[2*k]     = nlo2_r[k];
      num3[2*k+1]   = nhi2_r[k];
    end
    for (int j = 0; j < NDIV; j++) begin
      nabs3[j]    = num3[j][NW-1] ? NW'(0) - num3[j] : num3[j];
      tag3.neg[j] = num3[j][NW-1] ^ d2_r[j>>1][EW-1];
      rem3[j]     = XW'({nabs3[j][MW-1:0], {FRAC_BITS{1'b0}}});
      den3[j]     = XW'(dabs3[j>>1][C-1:0]);
    end
  end

  logic                    v3_r;
  tag_t                    tag3_r;
  logic [NDIV-1:0][XW-1:0] rem3_r, den3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag3_r <= tag3;
      rem3_r <= rem3;
      den3_r <= den3;
    end
  end

  // stage 4: quotient saturation check
  tag_t tag4;

  always_comb begin
    tag4 = tag3_r;
    for (int j = 0; j < NDIV; j++) begin
      tag4.sat[j] = rem3_r[j] >= (den3_r[j] << (C - 1));
    end
  end

  logic                    v4_r;
  tag_t                    tag4_r;
  logic [NDIV-1:0][XW-1:0] rem4_r, den4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag4_r <= tag4;
      rem4_r <= rem3_r;
      den4_r <= den3_r;
    end
  end

  // divider cell row
  logic                    cv [QW+1];
  tag_t                    ctag [QW+1];
  logic [NDIV-1:0][XW-1:0] crem [QW+1];
  logic [NDIV-1:0][XW-1:0] cden [QW+1];
  logic [NDIV-1:0][QW-1:0] cq [QW+1];

  assign cv[0]   = v4_r;
  assign ctag[0] = tag4_r;
  assign crem[0] = rem4_r;
  assign cden[0] = den4_r;
  assign cq[0]   = '0;

  for (genvar s = 0; s < QW; s++) begin : g_div
    aiq_div_cell #(
      .XW  (XW),
      .QW  (QW),
      .BIT (QW - 1 - s)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (cv[s]),
      .tag_i (ctag[s]),
      .rem_i (crem[s]),
      .den_i (cden[s]),
      .q_i   (cq[s]),
      .v_o   (cv[s+1]),
      .tag_o (ctag[s+1]),
      .rem_o (crem[s+1]),
      .den_o (cden[s+1]),
      .q_o   (cq[s+1])
    );
  end

  // quotient sign and saturation
  logic [NDIV-1:0][C-1:0] tf;

  always_comb begin
    for (int j = 0; j < NDIV; j++) begin
      if (ctag[QW].sat[j]) begin
        tf[j] = ctag[QW].neg[j] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
      end else if (ctag[QW].neg[j]) begin
        tf[j] = C'(0) - {1'b0, cq[QW][j]};
      end else begin
        tf[j] = {1'b0, cq[QW][j]};
      end
    end
  end

  logic                   vf_r;
  tag_t                   tagf_r;
  logic [NDIV-1:0][C-1:0] tf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= cv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tagf_r <= ctag[QW];
      tf_r   <= tf;
    end
  end

  // slab cell row
  logic                   sv [NAXIS+1];
  tag_t                   stag [NAXIS+1];
  logic [NDIV-1:0][C-1:0] st [NAXIS+1];
  logic signed [C-1:0]    ste [NAXIS+1];
  logic signed [C-1:0]    stx [NAXIS+1];
  logic                   sal [NAXIS+1];

  assign sv[0]   = vf_r;
  assign stag[0] = tagf_r;
  assign st[0]   = tf_r;
  assign ste[0]  = '0;
  assign stx[0]  = T_ONE;
  assign sal[0]  = 1'b1;

  for (genvar x = 0; x < NAXIS; x++) begin : g_slab
    aiq_slab_cell #(
      .CW   (C),
      .AXIS (x)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_i     (sv[x]),
      .tag_i   (stag[x]),
      .t_i     (st[x]),
      .te_i    (ste[x]),
      .tx_i    (stx[x]),
      .alive_i (sal[x]),
      .v_o     (sv[x+1]),
      .tag_o   (stag[x+1]),
      .t_o     (st[x+1]),
      .te_o    (ste[x+1]),
      .tx_o    (stx[x+1]),
      .alive_o (sal[x+1])
    );
  end

  // result select and output stage with skid
  logic hit_f, push, pop;
  logic out_valid_r, out_hit_r, sk_valid_r, sk_hit_r;

  always_comb begin
    unique case (stag[NAXIS].op)
      OP_BOX:     hit_f = stag[NAXIS].ok_box;
      OP_POINT:   hit_f = stag[NAXIS].ok_pt;
      OP_SEGMENT: hit_f = sal[NAXIS] && (ste[NAXIS] < stx[NAXIS]);
      OP_NONE:    hit_f = 1'b0;
    endcase
  end

  assign en   = !sk_valid_r;
  assign push = en && sv[NAXIS];
  assign pop  = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (sk_valid_r) begin
      if (pop) begin
        sk_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        sk_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_valid_r) begin
      if (pop) out_hit_r <= sk_hit_r;
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_hit_r <= hit_f;
      end else begin
        sk_hit_r <= hit_f;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = out_hit_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_valid_r) |-> $past(out_valid_r && !out_ch.ready))
    else $error("skid filled without an output stall");

  a_slab_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (sv[NAXIS] && stag[NAXIS].op == OP_SEGMENT && sal[NAXIS])
      |-> (ste[NAXIS] >= 0 && stx[NAXIS] <= T_ONE))
    else $error("segment interval left [0,1]");

endmodule

>>> test/aabb_intersection_query_tb.sv
// Self-checking testbench for the box intersection query block.
`timescale 1ns / 100ps

module aabb_intersection_query_tb;
  import aiq_pkg::*;

  localparam int CB = 32;
  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;
  localparam longint TLIM = 64'sd1 << (CB - 1);
  localparam int DRAIN = CB + 16;
  localparam int NPHASE = 8;
  localparam int PHASE_ITEMS = 170;

  typedef struct {
    op_t                  op;
    logic signed [CB-1:0] pa [3];
    logic signed [CB-1:0] pb [3];
    logic [CB-2:0]        oh [3];
  } query_t;

  logic clk;
  logic rst_n;

  aiq_query_if #(CB) in_if();
  aiq_result_if      out_if();
  aiq_cfg_if #(CB)   cfg_if();

  aabb_intersection_query #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if), .cfg_ch(cfg_if)
  );

  query_t query_q[$];
  bit     hit_q[$];
  query_t cur_query;
  longint box_c [3];
  longint box_h [3];
  int     in_idle_pct;
  int     out_stall_pct;
  bit     send_hold;
  bit     holdoff_req;
  bit     holdoff_seen;
  int     holdoff_left;
  int     errors;
  int     n_checked;
  int     n_hits;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("** aabb_intersection_query: FAILED **");
    $finish;
  end

  function automatic longint slab_quot(longint num, longint den);
    bit        neg;
    bit [63:0] n, d, qi, r, mag;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    qi = n / d;
    r = n % d;
    if (qi > (TLIM >> FB)) begin
      mag = TLIM;
    end else begin
      mag = qi << FB;
      for (int i = FB - 1; i >= 0; i--) begin
        r = r << 1;
        if (r >= d) begin
          r = r - d;
          mag[i] = 1'b1;
        end
      end
      if (mag > TLIM) mag = TLIM;
    end
    if (neg) return (mag == TLIM) ? -TLIM : -longint'(mag);
    if (mag > TLIM - 1) mag = TLIM - 1;
    return longint'(mag);
  endfunction

  function automatic bit predict_hit(query_t q);
    longint a, b, oh, dc, lo, hi, d, t1, t2, tmp, te, tx;
    bit     hit;
    hit = 1'b1;
    te = 0;
    tx = ONE;
    case (q.op)
      OP_BOX: begin
        for (int i = 0; i < 3; i++) begin
          a = q.pa[i];
          oh = longint'(q.oh[i]);
          dc = box_c[i] - a;
          if (dc < 0) dc = -dc;
          if (dc > box_h[i] + oh) hit = 1'b0;
        end
      end
      OP_POINT: begin
        for (int i = 0; i < 3; i++) begin
          a = q.pa[i];
          if (!(a > box_c[i] - box_h[i] && a < box_c[i] + box_h[i])) hit = 1'b0;
        end
      end
      OP_SEGMENT: begin
        for (int i = 0; i < 3 && hit; i++) begin
          a = q.pa[i];
          b = q.pb[i];
          lo = box_c[i] - box_h[i];
          hi = box_c[i] + box_h[i];
          d = b - a;
          if (d == 0) begin
            if (a < lo || a > hi) hit = 1'b0;
          end else begin
            t1 = slab_quot(lo - a, d);
            t2 = slab_quot(hi - a, d);
            if (t1 > t2) begin
              tmp = t1;
              t1 = t2;
              t2 = tmp;
            end
            if (te > t2 || t1 > tx) begin
              hit = 1'b0;
            end else begin
              if (t1 > te) te = t1;
              if (t2 < tx) tx = t2;
            end
          end
        end
        if (hit) hit = te < tx;
      end
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) hit_q.push_back(predict_hit(cur_query));
      if (!in_if.valid || in_if.ready) begin
        if (query_q.size() > 0 && !send_hold && $urandom_range(99) >= in_idle_pct) begin
          cur_query = query_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.opcode <= cur_query.op;
          in_if.point_a_x <= cur_query.pa[0];
          in_if.point_a_y <= cur_query.pa[1];
          in_if.point_a_z <= cur_query.pa[2];
          in_if.point_b_x <= cur_query.pb[0];
          in_if.point_b_y <= cur_query.pb[1];
          in_if.point_b_z <= cur_query.pb[2];
          in_if.other_half_x <= cur_query.oh[0];
          in_if.other_half_y <= cur_query.oh[1];
          in_if.other_half_z <= cur_query.oh[2];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    bit exp_hit;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      holdoff_left <= 0;
      holdoff_seen <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (hit_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual hit=%0b", $time, out_if.hit);
          errors++;
        end else begin
          exp_hit = hit_q.pop_front();
          n_checked++;
          n_hits += exp_hit;
          if (out_if.hit !== exp_hit) begin
            $display("%0t: hit mismatch, expected %0b actual %0b", $time, exp_hit, out_if.hit);
            errors++;
          end
        end
      end
      holdoff_seen <= holdoff_req;
      if (holdoff_req && !holdoff_seen) begin
        holdoff_left <= 300;
        out_if.ready <= 1'b0;
      end else if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= $urandom_range(99) >= out_stall_pct;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [CB-1:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.idx <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx < REG_HALF_X) box_c[idx] = longint'($signed(data));
    else box_h[idx - REG_HALF_X] = longint'(data[CB-2:0]);
  endtask

  task automatic set_box(logic [CB-1:0] cx, cy, cz, hx, hy, hz);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_HALF_X, hx);
    write_reg(REG_HALF_Y, hy);
    write_reg(REG_HALF_Z, hz);
  endtask

  task automatic wait_idle();
    while (query_q.size() > 0 || in_if.valid || hit_q.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] near_coord(int axis);
    longint span;
    span = box_h[axis] * 2 + (64'sd4 << FB);
    case ($urandom_range(7))
      0, 1: return $urandom;
      2: return box_c[axis] - box_h[axis] + $urandom_range(1) - $urandom_range(1);
      3: return box_c[axis] + box_h[axis] + $urandom_range(1) - $urandom_range(1);
      default: begin
        if (span > 64'sd2000000000) span = 64'sd2000000000;
        return box_c[axis] + longint'($urandom_range(int'(span))) - span / 2;
      end
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int     r;
    r = $urandom_range(15);
    q.op = r < 4 ? OP_BOX : r < 8 ? OP_POINT : r < 15 ? OP_SEGMENT : OP_NONE;
    for (int i = 0; i < 3; i++) begin
      q.pa[i] = near_coord(i);
      q.pb[i] = $urandom_range(5) == 0 ? q.pa[i] : near_coord(i);
      case ($urandom_range(3))
        0: q.oh[i] = $urandom;
        1: q.oh[i] = $urandom_range(1);
        default: q.oh[i] = $urandom_range(32'h0004_0000);
      endcase
    end
    return q;
  endfunction

  function automatic query_t mk(op_t op, logic signed [CB-1:0] ax, ay, az, bx, by, bz,
                                logic [CB-2:0] h);
    query_t q;
    q.op = op;
    q.pa = '{ax, ay, az};
    q.pb = '{bx, by, bz};
    q.oh = '{h, h, h};
    return q;
  endfunction

  task automatic load_directed();
    logic signed [CB-1:0] mx, mn, u;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    u = 32'sh0001_0000;
    query_q.push_back(mk(OP_BOX, 0, 0, 0, 0, 0, 0, 0));
    query_q.push_back(mk(OP_BOX, 3 * u, 2 * u, 3 * u, 0, 0, 0, u));
    query_q.push_back(mk(OP_BOX, 3 * u + 1, 2 * u, 3 * u, 0, 0, 0, u));
    query_q.push_back(mk(OP_BOX, mx, mn, mx, 0, 0, 0, 31'h7fff_ffff));
    query_q.push_back(mk(OP_BOX, mn, mx, mn, mx, mx, mx, 0));
    query_q.push_back(mk(OP_POINT, u, 2 * u, 3 * u, 0, 0, 0, 0));
    query_q.push_back(mk(OP_POINT, 0, 2 * u, 3 * u, 0, 0, 0, 0));
    query_q.push_back(mk(OP_POINT, 1, 2 * u + 1, 4 * u - 1, 0, 0, 0, 0));
    query_q.push_back(mk(OP_POINT, mx, mn, mx, 0, 0, 0, 0));
    query_q.push_back(mk(OP_SEGMENT, -u, 2 * u, 3 * u, 3 * u, 2 * u, 3 * u, 0));
    query_q.push_back(mk(OP_SEGMENT, u, 2 * u, 3 * u, u, 2 * u, 3 * u, 0));
    query_q.push_back(mk(OP_SEGMENT, 0, u, 2 * u, 0, u, 2 * u, 0));
    query_q.push_back(mk(OP_SEGMENT, 3 * u, 2 * u, 3 * u, 3 * u, 2 * u, 3 * u, 0));
    query_q.push_back(mk(OP_SEGMENT, -u, 2 * u, 3 * u, 0, 2 * u, 3 * u, 0));
    query_q.push_back(mk(OP_SEGMENT, mn, 2 * u, 3 * u, mx, 2 * u, 3 * u, 0));
    query_q.push_back(mk(OP_SEGMENT, mx, mx, mx, mn, mn, mn, 0));
    query_q.push_back(mk(OP_SEGMENT, mn, mn, mn, mn + 1, mn, mn, 0));
    query_q.push_back(mk(OP_SEGMENT, u, 2 * u, 3 * u, u + 1, 2 * u + 1, 3 * u + 1, 0));
    query_q.push_back(mk(OP_SEGMENT, 5 * u, 2 * u, 3 * u, 6 * u, 2 * u, 3 * u, 0));
    query_q.push_back(mk(OP_NONE, u, 2 * u, 3 * u, u, 2 * u, 3 * u, u));
    query_q.push_back(mk(OP_NONE, mx, mx, mx, mn, mn, mn, 31'h7fff_ffff));
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_BOX;
    in_if.point_a_x = '0;
    in_if.point_a_y = '0;
    in_if.point_a_z = '0;
    in_if.point_b_x = '0;
    in_if.point_b_y = '0;
    in_if.point_b_z = '0;
    in_if.other_half_x = '0;
    in_if.other_half_y = '0;
    in_if.other_half_z = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.idx = REG_CENTER_X;
    cfg_if.data = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    send_hold = 1'b0;
    holdoff_req = 1'b0;
    errors = 0;
    n_checked = 0;
    n_hits = 0;
    for (int i = 0; i < 3; i++) begin
      box_c[i] = 0;
      box_h[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_directed();
    wait_idle();
    set_box(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
            32'h0001_0000, 32'h0000_8000, 32'h0001_0000);
    load_directed();
    wait_idle();

    for (int p = 0; p < NPHASE; p++) begin
      case (p)
        0: set_box(0, 0, 0, 0, 0, 0);
        1: set_box(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        2: set_box(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 1, 32'h7fff_ffff);
        default: set_box($urandom_range(32'h0010_0000) - 32'h0008_0000,
                         $urandom, $urandom_range(32'h0010_0000) - 32'h0008_0000,
                         $urandom_range(32'h0004_0000), $urandom_range(32'h0004_0000),
                         p == 3 ? $urandom : $urandom_range(32'h0004_0000));
      endcase
      case (p % 4)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 72; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 72; end
        default: begin in_idle_pct = 33; out_stall_pct = 33; end
      endcase
      for (int k = 0; k < PHASE_ITEMS / 2; k++) query_q.push_back(rand_query());
      if (p == 4) holdoff_req = 1'b1;
      if (p == 5) begin
        while (query_q.size() > 0) @(posedge clk);
        send_hold = 1'b1;
        while (in_if.valid || hit_q.size() > 0) @(posedge clk);
        send_hold = 1'b0;
      end
      for (int k = 0; k < PHASE_ITEMS / 2; k++) query_q.push_back(rand_query());
      wait_idle();
      holdoff_req = 1'b0;
    end

    $display("Checked %0d query results (%0d hits) over %0d box settings,", n_checked, n_hits,
             NPHASE + 2);
    $display("covering box, point, segment and unused opcodes under mixed flow control.");
    if (errors == 0) begin
      $display("** aabb_intersection_query: PASSED **");
    end else begin
      $display("** aabb_intersection_query: FAILED **");
    end
    $finish;
  end

endmodule
